@@ design/lrfp_pkg.sv @@
// Package for the launch record field parser.
// Holds widths, character codes, status codes and the word types shared between the modules.
// No dependencies.
package lrfp_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int SECS_WIDTH  = 40;
  localparam int NUM_VALUES  = 8;
  localparam int IDX_WIDTH   = $clog2(NUM_VALUES);
  localparam int FIELD_WIDTH = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
  localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FIELD_WIDTH-1:0] FIELD_NAME     = FIELD_WIDTH'(0);
  localparam logic [FIELD_WIDTH-1:0] FIELD_LAST_SEP = FIELD_WIDTH'(2);
  localparam logic [FIELD_WIDTH-1:0] FIELD_DONE     = FIELD_WIDTH'(9);

  localparam logic [7:0] CH_ERR   = 8'h65;  // 'e'
  localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
  localparam logic [7:0] CH_NONE  = 8'h6e;  // 'n'
  localparam logic [7:0] CH_SEMI  = 8'h3b;  // ';'
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] DIGIT_LO = 8'd48;
  localparam logic [7:0] DIGIT_HI = 8'd57;

  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;

  localparam logic [SECS_WIDTH-1:0] SECS_PER_DAY  = SECS_WIDTH'(24 * 60 * 60);
  localparam logic [SECS_WIDTH-1:0] SECS_PER_HOUR = SECS_WIDTH'(60 * 60);
  localparam logic [SECS_WIDTH-1:0] SECS_PER_MIN  = SECS_WIDTH'(60);

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_ERROR = 2'd1,
    ST_NONE  = 2'd2
  } status_e;

  // Classified byte word from the front to the back.
  typedef struct packed {
    logic       feed;
    logic       sep;
    logic       digit;
    logic [3:0] digit_val;
    logic       last;
    status_e    mode;
  } cmd_t;

  // End-of-reply snapshot handed to the seconds/output stage.
  typedef struct packed {
    status_e                                mode;
    logic [NUM_VALUES-1:0][VALUE_WIDTH-1:0] vals;
  } snap_t;

endpackage

@@ design/lrfp_front.sv @@
// Front end: accepts reply bytes, detects the error and no-mission markers,
// and classifies each byte into a command word. Depends on lrfp_pkg.
module lrfp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          text_byte_i,
  input  logic                end_of_reply_i,
  input  logic                q_full_i,
  output logic                in_stall_o,
  output logic                push_o,
  output lrfp_pkg::cmd_t      cmd_o
);

  lrfp_pkg::status_e mode_q, mode_d, mode_n;
  logic [1:0]        pos_q, pos_d;
  logic [7:0]        first_q, first_d;
  logic [7:0]        digit_off;
  logic              accept;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign push_o     = accept;
  assign digit_off  = text_byte_i - lrfp_pkg::DIGIT_LO;

  always_comb begin
    mode_n  = mode_q;
    pos_d   = pos_q;
    first_d = first_q;
    cmd_o.feed = 1'b0;
    if (mode_q == lrfp_pkg::ST_VALID) begin
      cmd_o.feed = 1'b1;
      if (pos_q == 2'd1 && first_q == lrfp_pkg::CH_ERR && text_byte_i == lrfp_pkg::CH_BANG) begin
        mode_n     = lrfp_pkg::ST_ERROR;
        cmd_o.feed = 1'b0;
      end else if (pos_q == 2'd1 && first_q == lrfp_pkg::CH_NONE &&
                   text_byte_i == lrfp_pkg::CH_BANG) begin
        mode_n     = lrfp_pkg::ST_NONE;
        cmd_o.feed = 1'b0;
      end
      if (pos_q == 2'd0) begin
        first_d = text_byte_i;
      end
      if (pos_q < 2'd2) begin
        pos_d = pos_q + 2'd1;
      end
    end
    mode_d = mode_n;
    if (end_of_reply_i) begin
      mode_d  = lrfp_pkg::ST_VALID;
      pos_d   = 2'd0;
      first_d = 8'd0;
    end
    cmd_o.sep = (text_byte_i == lrfp_pkg::CH_SEMI) || (text_byte_i == lrfp_pkg::CH_LF) ||
                (text_byte_i == lrfp_pkg::CH_CR);
    cmd_o.digit = (text_byte_i >= lrfp_pkg::DIGIT_LO) && (text_byte_i <= lrfp_pkg::DIGIT_HI);
    cmd_o.digit_val = digit_off[3:0];
    cmd_o.last      = end_of_reply_i;
    cmd_o.mode      = mode_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= lrfp_pkg::ST_VALID;
      pos_q   <= 2'd0;
      first_q <= 8'd0;
    end else if (accept) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      first_q <= first_d;
    end
  end

endmodule

@@ design/lrfp_queue.sv @@
// Short command queue between the front and the back end.
// Depends on lrfp_pkg.
module lrfp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lrfp_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output lrfp_pkg::cmd_t cmd_o,
  output logic           empty_o,
  output logic           full_o
);

  lrfp_pkg::cmd_t                      mem_q [lrfp_pkg::QUEUE_DEPTH];
  logic [lrfp_pkg::PTR_WIDTH-1:0]      wr_ptr_q, rd_ptr_q;
  logic [lrfp_pkg::CNT_WIDTH-1:0]      count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == lrfp_pkg::CNT_WIDTH'(lrfp_pkg::QUEUE_DEPTH));
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("queue underflow");

endmodule

@@ design/lrfp_back.sv @@
// Back end: walks the reply fields, accumulates digits and stores field values;
// snapshots the values at the end of each reply. Depends on lrfp_pkg.
module lrfp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lrfp_pkg::cmd_t cmd_i,
  input  logic           empty_i,
  output logic           pop_o,
  input  logic           snap_ready_i,
  output logic           snap_valid_o,
  output lrfp_pkg::snap_t snap_o
);

  localparam int AccWidth = lrfp_pkg::VALUE_WIDTH + 4;

  logic [lrfp_pkg::FIELD_WIDTH-1:0] field_q, field_d, field_m1;
  logic [lrfp_pkg::VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                             stop_q, stop_d;
  logic [lrfp_pkg::NUM_VALUES-1:0][lrfp_pkg::VALUE_WIDTH-1:0] vals_q, vals_d;
  logic [AccWidth-1:0]              acc_mul;
  logic                             ends, next_f, b_ready;
  logic                             b_valid_q;
  lrfp_pkg::snap_t                  b_snap_q;

  assign b_ready      = !b_valid_q || snap_ready_i;
  assign pop_o        = !empty_i && (!cmd_i.last || b_ready);
  assign snap_valid_o = b_valid_q;
  assign snap_o       = b_snap_q;
  assign field_m1     = field_q - 1'b1;
  assign acc_mul      = (AccWidth'(acc_q) << 3) + (AccWidth'(acc_q) << 1) +
                        AccWidth'(cmd_i.digit_val);
  assign ends         = (field_q <= lrfp_pkg::FIELD_LAST_SEP) ? cmd_i.sep : !cmd_i.digit;

  always_comb begin
    field_d = field_q;
    acc_d   = acc_q;
    stop_d  = stop_q;
    vals_d  = vals_q;
    next_f  = 1'b0;
    if (pop_o && cmd_i.feed) begin
      if (field_q == lrfp_pkg::FIELD_NAME) begin
        next_f = cmd_i.sep;
      end else if (field_q < lrfp_pkg::FIELD_DONE) begin
        if (ends) begin
          vals_d[field_m1[lrfp_pkg::IDX_WIDTH-1:0]] = acc_q;
          next_f = 1'b1;
        end else if (!stop_q) begin
          if (cmd_i.digit) begin
            acc_d = (acc_mul > AccWidth'(lrfp_pkg::VALUE_MAX)) ? lrfp_pkg::VALUE_MAX :
                    acc_mul[lrfp_pkg::VALUE_WIDTH-1:0];
          end else begin
            stop_d = 1'b1;
          end
        end
      end
    end
    if (next_f) begin
      field_d = field_q + 1'b1;
      acc_d   = '0;
      stop_d  = 1'b0;
    end
    if (pop_o && cmd_i.last) begin
      field_d = lrfp_pkg::FIELD_NAME;
      acc_d   = '0;
      stop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q   <= lrfp_pkg::FIELD_NAME;
      acc_q     <= '0;
      stop_q    <= 1'b0;
      vals_q    <= '0;
      b_valid_q <= 1'b0;
    end else begin
      field_q <= field_d;
      acc_q   <= acc_d;
      stop_q  <= stop_d;
      vals_q  <= vals_d;
      if (pop_o && cmd_i.last) begin
        b_valid_q <= 1'b1;
      end else if (snap_ready_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.last) begin
      b_snap_q.mode <= cmd_i.mode;
      b_snap_q.vals <= vals_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) field_q <= lrfp_pkg::FIELD_DONE)
    else $error("field counter past last field");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (pop_o && cmd_i.last) |=> (field_q == lrfp_pkg::FIELD_NAME && !stop_q))
    else $error("per-reply state not cleared at end of reply");

endmodule

@@ design/lrfp_out.sv @@
// Result stage: multiplies the stored countdown by the seconds constants, sums
// them and holds the result word with the sticky flag. Depends on lrfp_pkg.
module lrfp_out (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                snap_valid_i,
  input  lrfp_pkg::snap_t                     snap_i,
  output logic                                snap_ready_o,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [1:0]                          reply_status_o,
  output logic [lrfp_pkg::NUM_VALUES-1:0][lrfp_pkg::VALUE_WIDTH-1:0] vals_o,
  output logic [lrfp_pkg::SECS_WIDTH-1:0]     seconds_total_o,
  output logic                                extracted_flag_o
);

  logic                               c_valid_q, out_valid_q, out_ready;
  lrfp_pkg::snap_t                    c_snap_q;
  logic [lrfp_pkg::SECS_WIDTH-1:0]    prod_day_q, prod_hour_q, prod_min_q, sum;
  lrfp_pkg::status_e                  status_q;
  logic [lrfp_pkg::NUM_VALUES-1:0][lrfp_pkg::VALUE_WIDTH-1:0] vals_q;
  logic [lrfp_pkg::SECS_WIDTH-1:0]    secs_q;
  logic                               ext_q;

  assign out_ready    = !out_valid_q || !out_stall_i;
  assign snap_ready_o = !c_valid_q || out_ready;
  assign sum          = prod_day_q + prod_hour_q + prod_min_q;

  assign out_valid_o      = out_valid_q;
  assign reply_status_o   = status_q;
  assign vals_o           = vals_q;
  assign seconds_total_o  = secs_q;
  assign extracted_flag_o = ext_q;

  always_ff @(posedge clk_i) begin
    if (snap_ready_o && snap_valid_i) begin
      c_snap_q    <= snap_i;
      prod_day_q  <= lrfp_pkg::SECS_WIDTH'(snap_i.vals[0]) * lrfp_pkg::SECS_PER_DAY;
      prod_hour_q <= lrfp_pkg::SECS_WIDTH'(snap_i.vals[1]) * lrfp_pkg::SECS_PER_HOUR;
      prod_min_q  <= lrfp_pkg::SECS_WIDTH'(snap_i.vals[2]) * lrfp_pkg::SECS_PER_MIN;
    end
    if (out_ready && c_valid_q) begin
      status_q <= c_snap_q.mode;
      vals_q   <= c_snap_q.vals;
    end
  end

  // secs_q and ext_q also carry the persistent seconds and extracted state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      secs_q      <= '0;
      ext_q       <= 1'b0;
    end else begin
      if (snap_ready_o) begin
        c_valid_q <= snap_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= c_valid_q;
        if (c_valid_q) begin
          if (c_snap_q.mode == lrfp_pkg::ST_VALID) begin
            secs_q <= sum;
          end
          if (c_snap_q.mode != lrfp_pkg::ST_ERROR) begin
            ext_q <= 1'b1;
          end
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(ext_q))
    else $error("extracted flag dropped");

endmodule

@@ design/launch_record_field_parser_core.sv @@
// Launch record field parser, top level: front end, command queue, back end, result stage.
// Depends on lrfp_pkg, lrfp_front, lrfp_queue, lrfp_back, lrfp_out.
// Throughput: one byte per cycle while in_stall_o is low; the back end retires one queued
// byte word per cycle unless an end-of-reply word waits for a free snapshot register. A result
// passes the queue, the end-of-reply snapshot, the seconds multiply and the output register.
// Reset clears all control state, the stored values, seconds and the extracted flag.
module launch_record_field_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_reply_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  reply_status_o,
  output logic [lrfp_pkg::VALUE_WIDTH-1:0] days_left_o,
  output logic [lrfp_pkg::VALUE_WIDTH-1:0] hours_left_o,
  output logic [lrfp_pkg::VALUE_WIDTH-1:0] minutes_left_o,
  output logic [lrfp_pkg::VALUE_WIDTH-1:0] year_value_o,
  output logic [lrfp_pkg::VALUE_WIDTH-1:0] month_value_o,
  output logic [lrfp_pkg::VALUE_WIDTH-1:0] day_value_o,
  output logic [lrfp_pkg::VALUE_WIDTH-1:0] hour_value_o,
  output logic [lrfp_pkg::VALUE_WIDTH-1:0] minute_value_o,
  output logic [lrfp_pkg::SECS_WIDTH-1:0]  seconds_total_o,
  output logic        extracted_flag_o
);

  lrfp_pkg::cmd_t  push_cmd, head_cmd;
  lrfp_pkg::snap_t snap;
  logic            push, pop, q_empty, q_full, snap_valid, snap_ready;
  logic [lrfp_pkg::NUM_VALUES-1:0][lrfp_pkg::VALUE_WIDTH-1:0] vals;

  lrfp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .text_byte_i    (text_byte_i),
    .end_of_reply_i (end_of_reply_i),
    .q_full_i       (q_full),
    .in_stall_o     (in_stall_o),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  lrfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  lrfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (head_cmd),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .snap_ready_i (snap_ready),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  lrfp_out u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .snap_valid_i     (snap_valid),
    .snap_i           (snap),
    .snap_ready_o     (snap_ready),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .reply_status_o   (reply_status_o),
    .vals_o           (vals),
    .seconds_total_o  (seconds_total_o),
    .extracted_flag_o (extracted_flag_o)
  );

  assign days_left_o    = vals[0];
  assign hours_left_o   = vals[1];
  assign minutes_left_o = vals[2];
  assign year_value_o   = vals[3];
  assign month_value_o  = vals[4];
  assign day_value_o    = vals[5];
  assign hour_value_o   = vals[6];
  assign minute_value_o = vals[7];

endmodule
